/* src/assert_macros.svh */
// Assertion macros used by the hop-distance unit RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/bbfs_pkg.sv */
// Package for the bidirectional BFS hop-distance unit.
// Holds request codes, result codes, FSM states and controller/datapath structs.
package bbfs_pkg;

	localparam int VTX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int DIST_W = 12;
	localparam int LEN_W  = 11;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] VC_RESET = 11'd1024;
	localparam logic [LEN_W-1:0] LEN_MAX  = 11'd1023;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_CLEAR, ST_INIT_SRC, ST_INIT_DST, ST_PICK,
		ST_FETCH, ST_FETCH_W, ST_XD_W, ST_EDGE, ST_EDGE_W, ST_DV_W, ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		RES_RANGE, RES_SAME, RES_UNREACH, RES_MET
	} res_t;

	typedef struct packed {
		logic store_clr;
		logic store_add;
		logic latch_query;
		logic clr_step;
		logic init_src;
		logic init_dst;
		logic pick;
		logic swap;
		logic q_rd;
		logic x_latch;
		logic dx_latch;
		logic e_rd;
		logic next_pass;
		logic e_next;
		logic v_rd;
		logic visit;
		logic hops_latch;
		logic i_next;
		logic out_load;
		res_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic bad_range;
		logic same;
		logic clr_last;
		logic cur_empty;
		logic level_done;
		logic edges_done;
		logic pass1;
		logic edge_hit;
		logic dv_zero;
		logic dv_opp;
	} stat_t;

endpackage

/* src/bbfs_dp.sv */
// Datapath of the hop-distance unit: edge store, distance store, frontier queues.
// Depends on bbfs_pkg; driven by bbfs_ctrl through cmd_t / stat_t.
module bbfs_dp
	import bbfs_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CNT_W-1:0]        cfg_data,
	input  logic [VTX_W-1:0]        first_vertex,
	input  logic [VTX_W-1:0]        second_vertex,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	output logic signed [LEN_W-1:0] path_length,
	output logic [STAT_W-1:0]       query_status
);

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ESW = $clog2(MAX_EDGES + 1);
	localparam int FCW = $clog2(MAX_VERTICES + 1);

	logic [CNT_W-1:0] vc_q;
	logic [ESW-1:0]   edges_q;
	logic             dropped_q;
	logic [VTX_W-1:0] src_q, dst_q, x_q;
	logic [CNT_W-1:0] clr_q;
	logic [1:0]       s1_q, s2_q, sp_q;
	logic [FCW-1:0]   n1_q, n2_q, nsp_q, i_q;
	logic             side_q, pass_q;
	logic signed [DIST_W-1:0] dx_q;
	logic [ESW-1:0]   e_q;
	logic [LEN_W-1:0] hops_q;

	logic [VTX_W-1:0] tail_mem [MAX_EDGES];
	logic [VTX_W-1:0] head_mem [MAX_EDGES];
	logic [VTX_W-1:0] tail_rd_q, head_rd_q;
	logic signed [DIST_W-1:0] dist_mem [MAX_VERTICES];
	logic signed [DIST_W-1:0] dist_rd_q;
	logic [VTX_W-1:0] q_mem [4*MAX_VERTICES];
	logic [VTX_W-1:0] q_rd_q;

	logic [CNT_W-1:0] count;
	logic [VTX_W-1:0] ea, ev;
	logic [1:0]       cur;
	logic             full;
	logic             dist_we;
	logic [VAW-1:0]   dist_wa, dist_ra;
	logic signed [DIST_W-1:0] dist_wd;
	logic             q_we;
	logic [VAW+1:0]   q_wa;
	logic [VTX_W-1:0] q_wd;
	logic signed [DIST_W:0] diff, hraw;

	// effective count = min(register, MAX_VERTICES)
	assign count = (32'(vc_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : vc_q;
	assign full  = (32'(edges_q) >= MAX_EDGES);
	assign ea    = pass_q ? head_rd_q : tail_rd_q;
	assign ev    = pass_q ? tail_rd_q : head_rd_q;
	assign cur   = side_q ? s1_q : s2_q;

	assign diff = side_q ? (DIST_W+1)'(dx_q) - (DIST_W+1)'(dist_rd_q)
	                     : (DIST_W+1)'(dist_rd_q) - (DIST_W+1)'(dx_q);
	assign hraw = diff - 13'sd1;

	always_comb begin
		stat.bad_range  = ({1'b0, src_q} >= count) || ({1'b0, dst_q} >= count);
		stat.same       = (src_q == dst_q);
		stat.clr_last   = (clr_q == count - 11'd1);
		stat.cur_empty  = (n1_q <= n2_q) ? (n1_q == '0) : (n2_q == '0);
		stat.level_done = (i_q == (side_q ? n1_q : n2_q));
		stat.edges_done = (e_q == edges_q);
		stat.pass1      = pass_q;
		stat.edge_hit   = (ea == x_q) && ({1'b0, ev} < count);
		stat.dv_zero    = (dist_rd_q == '0);
		stat.dv_opp     = side_q ? (dist_rd_q < 0) : (dist_rd_q > 0);
	end

	// distance store write/read ports
	always_comb begin
		dist_we = cmd.clr_step | cmd.init_src | cmd.init_dst | cmd.visit;
		dist_wa = VAW'(clr_q);
		dist_wd = '0;
		if (cmd.init_src) begin
			dist_wa = VAW'(src_q);
			dist_wd = 12'sd1;
		end else if (cmd.init_dst) begin
			dist_wa = VAW'(dst_q);
			dist_wd = -12'sd1;
		end else if (cmd.visit) begin
			dist_wa = VAW'(ev);
			dist_wd = side_q ? dx_q + 12'sd1 : dx_q - 12'sd1;
		end
		dist_ra = cmd.v_rd ? VAW'(ev) : VAW'(q_rd_q);
	end

	// frontier queue write port; bank in the top two address bits
	always_comb begin
		q_we = cmd.init_src | cmd.init_dst | cmd.visit;
		q_wa = {2'd0, VAW'(0)};
		q_wd = src_q;
		if (cmd.init_dst) begin
			q_wa = {2'd1, VAW'(0)};
			q_wd = dst_q;
		end else if (cmd.visit) begin
			q_wa = {sp_q, VAW'(nsp_q)};
			q_wd = ev;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_add && !full) begin
			tail_mem[EIW'(edges_q)] <= first_vertex;
			head_mem[EIW'(edges_q)] <= second_vertex;
		end
		if (cmd.e_rd) begin
			tail_rd_q <= tail_mem[EIW'(e_q)];
			head_rd_q <= head_mem[EIW'(e_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (dist_we)
			dist_mem[dist_wa] <= dist_wd;
		if (cmd.x_latch || cmd.v_rd)
			dist_rd_q <= dist_mem[dist_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we)
			q_mem[q_wa] <= q_wd;
		if (cmd.q_rd)
			q_rd_q <= q_mem[{cur, VAW'(i_q)}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q      <= VC_RESET;
			edges_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cfg_we)
				vc_q <= cfg_data;
			if (cmd.store_clr) begin
				edges_q   <= '0;
				dropped_q <= 1'b0;
			end else if (cmd.store_add) begin
				if (full)
					dropped_q <= 1'b1;
				else
					edges_q <= edges_q + ESW'(1);
			end
		end
	end

	// search registers (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.latch_query) begin
			src_q <= first_vertex;
			dst_q <= second_vertex;
			clr_q <= '0;
		end
		if (cmd.clr_step)
			clr_q <= clr_q + 11'd1;
		if (cmd.init_dst) begin
			s1_q  <= 2'd0;
			s2_q  <= 2'd1;
			sp_q  <= 2'd2;
			n1_q  <= FCW'(1);
			n2_q  <= FCW'(1);
			nsp_q <= '0;
		end
		if (cmd.pick) begin
			side_q <= (n1_q <= n2_q);
			i_q    <= '0;
			nsp_q  <= '0;
		end
		if (cmd.swap) begin
			sp_q  <= cur;
			nsp_q <= side_q ? n1_q : n2_q;
			if (side_q) begin
				s1_q <= sp_q;
				n1_q <= nsp_q;
			end else begin
				s2_q <= sp_q;
				n2_q <= nsp_q;
			end
		end
		if (cmd.visit && (32'(nsp_q) < MAX_VERTICES))
			nsp_q <= nsp_q + FCW'(1);
		if (cmd.x_latch)
			x_q <= q_rd_q;
		if (cmd.dx_latch) begin
			dx_q   <= dist_rd_q;
			e_q    <= '0;
			pass_q <= 1'b0;
		end
		if (cmd.next_pass) begin
			e_q    <= '0;
			pass_q <= 1'b1;
		end
		if (cmd.e_next)
			e_q <= e_q + ESW'(1);
		if (cmd.i_next)
			i_q <= i_q + FCW'(1);
		if (cmd.hops_latch)
			hops_q <= (hraw > 13'sd1023) ? LEN_MAX : hraw[LEN_W-1:0];
		if (cmd.out_load) begin
			case (cmd.out_kind)
				RES_RANGE: begin
					path_length  <= '0;
					query_status <= STAT_RANGE;
				end
				RES_SAME: begin
					path_length  <= '0;
					query_status <= dropped_q ? STAT_DROPPED : STAT_OK;
				end
				RES_UNREACH: begin
					path_length  <= -11'sd1;
					query_status <= dropped_q ? STAT_DROPPED : STAT_OK;
				end
				default: begin
					path_length  <= hops_q;
					query_status <= dropped_q ? STAT_DROPPED : STAT_OK;
				end
			endcase
		end
	end

endmodule

/* src/bbfs_ctrl.sv */
// Controller FSM of the hop-distance unit: request handshake and search sequencing.
// Depends on bbfs_pkg and assert_macros.svh; commands bbfs_dp.
`include "assert_macros.svh"
module bbfs_ctrl
	import bbfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	output logic       out_valid,
	input  logic       out_stall,
	input  stat_t      stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	res_t   kind_q, kind_d;
	logic   out_valid_q;
	logic   in_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= RES_RANGE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		cmd          = '0;
		cmd.out_kind = kind_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (mode)
						MODE_CLEAR: cmd.store_clr = 1'b1;
						MODE_ADD:   cmd.store_add = 1'b1;
						MODE_QUERY: begin
							cmd.latch_query = 1'b1;
							state_d         = ST_CHECK;
						end
						default: ;
					endcase
				end
			end
			ST_CHECK: begin
				if (stat.bad_range) begin
					kind_d  = RES_RANGE;
					state_d = ST_RESULT;
				end else if (stat.same) begin
					kind_d  = RES_SAME;
					state_d = ST_RESULT;
				end else begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last)
					state_d = ST_INIT_SRC;
			end
			ST_INIT_SRC: begin
				cmd.init_src = 1'b1;
				state_d      = ST_INIT_DST;
			end
			ST_INIT_DST: begin
				cmd.init_dst = 1'b1;
				state_d      = ST_PICK;
			end
			ST_PICK: begin
				if (stat.cur_empty) begin
					kind_d  = RES_UNREACH;
					state_d = ST_RESULT;
				end else begin
					cmd.pick = 1'b1;
					state_d  = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (stat.level_done) begin
					cmd.swap = 1'b1;
					state_d  = ST_PICK;
				end else begin
					cmd.q_rd = 1'b1;
					state_d  = ST_FETCH_W;
				end
			end
			ST_FETCH_W: begin
				cmd.x_latch = 1'b1;
				state_d     = ST_XD_W;
			end
			ST_XD_W: begin
				cmd.dx_latch = 1'b1;
				state_d      = ST_EDGE;
			end
			ST_EDGE: begin
				if (stat.edges_done) begin
					if (stat.pass1) begin
						cmd.i_next = 1'b1;
						state_d    = ST_FETCH;
					end else begin
						cmd.next_pass = 1'b1;
					end
				end else begin
					cmd.e_rd = 1'b1;
					state_d  = ST_EDGE_W;
				end
			end
			ST_EDGE_W: begin
				if (stat.edge_hit) begin
					cmd.v_rd = 1'b1;
					state_d  = ST_DV_W;
				end else begin
					cmd.e_next = 1'b1;
					state_d    = ST_EDGE;
				end
			end
			ST_DV_W: begin
				if (stat.dv_zero) begin
					cmd.visit  = 1'b1;
					cmd.e_next = 1'b1;
					state_d    = ST_EDGE;
				end else if (stat.dv_opp) begin
					cmd.hops_latch = 1'b1;
					kind_d         = RES_MET;
					state_d        = ST_RESULT;
				end else begin
					cmd.e_next = 1'b1;
					state_d    = ST_EDGE;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`ASSERT_CLK(a_query_enters_check, (in_acc && mode == MODE_QUERY) |=> (state_q == ST_CHECK), "query not started")
	`ASSERT_CLK(a_result_from_result_state, $rose(out_valid_q) |-> ($past(state_q) == ST_RESULT), "result raised outside result state")
	`ASSERT_IMPL(a_no_double_load, cmd.out_load, (!out_valid_q || !out_stall), "result overwritten while stalled")

endmodule

/* src/bidirectional_bfs_hop_distance_unit.sv */
// Top level of the bidirectional BFS hop-distance unit.
// Depends on bbfs_pkg, bbfs_ctrl and bbfs_dp.
// Requests: mode 0 clears the edge store, mode 1 appends an undirected edge, mode 2 asks
// for the hop distance between two vertices and returns one result; mode 3 is ignored.
// Clear and add requests are handled in the idle state and are accepted back to back. A
// query runs from an FSM over the edge, distance and frontier memories: it first sweeps
// the distance store, one entry a cycle for the effective vertex count, then expands the
// smaller frontier one level at a time. Each frontier vertex is read from its queue, its
// distance is fetched, and the stored edges are scanned twice, once in each direction;
// an edge into an unvisited vertex adds it to the next frontier, and an edge into the
// other side's area ends the search. Range errors and same-vertex queries go from the
// check state straight to the result state. in_stall stays high for the whole query.
// The result sits in an output register, so the next request is taken as soon as the
// result is loaded, even if the consumer is still stalling it.
module bidirectional_bfs_hop_distance_unit
	import bbfs_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// vertex_count register
	input  logic                    cfg_we,
	input  logic [CNT_W-1:0]        cfg_data,
	// request channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              mode,
	input  logic [VTX_W-1:0]        first_vertex,
	input  logic [VTX_W-1:0]        second_vertex,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [LEN_W-1:0] path_length,
	output logic [STAT_W-1:0]       query_status
);

	cmd_t  cmd;
	stat_t stat;

	// sequencing and handshake
	bbfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// memories, counters and the result register
	bbfs_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.cmd           (cmd),
		.stat          (stat),
		.path_length   (path_length),
		.query_status  (query_status)
	);

endmodule
